// ===== hw/rtl/bma_pkg.sv =====
// Package for the boxcar moving average block.
// Holds the field widths, the reset window size and the controller state codes.
// No dependencies.
package bma_pkg;

  // Payload widths of the sample and average fields.
  localparam int SampleW = 16;
  localparam int AverageW = 16;

  // Width of the window_size register and its value after reset.
  localparam int CfgW = 9;
  localparam logic [CfgW-1:0] WindowSizeReset = 9'd8;

  // Default depth of the sample ring.
  localparam int WindowMaxDefault = 256;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

// ===== hw/rtl/bma_if.sv =====
// Stream interfaces of the boxcar moving average block.
// One channel carries samples in, the other carries averages out.
// Depends on bma_pkg for the payload widths.
interface bma_sample_if;
  logic                           valid;
  logic                           ready;
  logic [bma_pkg::SampleW-1:0]    sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bma_average_if;
  logic                           valid;
  logic                           ready;
  logic [bma_pkg::AverageW-1:0]   average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

// ===== hw/rtl/boxcar_moving_average_top.sv =====
// Top level of the boxcar moving average block: sample ring memory,
// running sum, iterative divider and output register.
// Depends on bma_pkg and the stream interfaces in bma_if.sv.
//
//   Channel      Direction  Payload            Transaction when
//   sample_i     in         sample [15:0]      valid && ready
//   average_o    out        average [15:0]     valid && ready
//   window_size  in         window_size [8:0]  window_size_we_i
//
// Each sample goes through the ring read on accept, the sum update and ring
// write, the restoring divider at one quotient bit a cycle, and the output
// register load, in that order.
// The output register lets the next sample be taken while an average waits.
// Reset and a window_size write clear the sum, write pointer and full flag; the
// ring itself needs no clearing pass, since entries are read as zero until the
// ring has wrapped. A stalled output holds the divider result until taken.
module boxcar_moving_average_top #(
  parameter int WINDOW_MAX = bma_pkg::WindowMaxDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bma_sample_if.sink                  sample_i,
  bma_average_if.source               average_o,
  input  logic                        window_size_we_i,
  input  logic [bma_pkg::CfgW-1:0]    window_size_i
);

  localparam int AddrW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W = $clog2(WINDOW_MAX * 65535 + 1);
  localparam int DivW = bma_pkg::CfgW;
  localparam int CntW = $clog2(SUM_W + 1);
  localparam int SampleW = bma_pkg::SampleW;

  bma_pkg::state_e state_q, state_d;

  logic [DivW-1:0]    ws_q;
  logic [AddrW-1:0]   pos_q;
  logic               full_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SampleW-1:0] sample_q;
  logic [SampleW-1:0] rdata_q;

  logic [SampleW-1:0] ring_q [WINDOW_MAX];

  logic [DivW-1:0]    div_q;
  logic [DivW-1:0]    rem_q;
  logic [SUM_W-1:0]   quo_q;
  logic [CntW-1:0]    cnt_q;

  logic                          out_valid_q;
  logic [bma_pkg::AverageW-1:0]  out_avg_q;

  logic in_fire;
  logic out_free;

  assign in_fire  = sample_i.valid && sample_i.ready;
  assign out_free = !out_valid_q || average_o.ready;

  assign sample_i.ready    = (state_q == bma_pkg::S_IDLE);
  assign average_o.valid   = out_valid_q;
  assign average_o.average = out_avg_q;

  // Clamp of a written window size into 1..WINDOW_MAX.
  logic [DivW-1:0] ws_clamped;
  always_comb begin
    ws_clamped = window_size_i;
    if (window_size_i == '0) begin
      ws_clamped = DivW'(1);
    end else if (32'(window_size_i) > WINDOW_MAX) begin
      ws_clamped = DivW'(WINDOW_MAX);
    end
  end

  // Sum update and pointer advance, used in the read state.
  logic [AddrW:0]     pos_inc;
  logic               wrap;
  logic [AddrW-1:0]   pos_next;
  logic               full_next;
  logic [SampleW-1:0] old_sample;
  logic [SUM_W-1:0]   sum_next;
  logic [DivW-1:0]    div_next;
  always_comb begin
    pos_inc    = {1'b0, pos_q} + (AddrW+1)'(1);
    wrap       = 32'(pos_inc) >= 32'(ws_q);
    pos_next   = wrap ? '0 : pos_inc[AddrW-1:0];
    full_next  = full_q || wrap;
    // Before the ring wraps, the entry at the pointer has not been written since clearing.
    old_sample = full_q ? rdata_q : '0;
    sum_next   = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
    div_next   = full_next ? ws_q : DivW'(pos_inc);
    if (div_next == '0) begin
      div_next = DivW'(1);
    end
  end

  // One restoring division step.
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            fits;
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    diff  = trial - {1'b0, div_q};
    fits  = (trial >= {1'b0, div_q});
  end

  // Controller.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bma_pkg::S_IDLE: begin
        if (in_fire) state_d = bma_pkg::S_READ;
      end
      bma_pkg::S_READ: state_d = bma_pkg::S_DIV;
      bma_pkg::S_DIV: begin
        if (cnt_q == CntW'(SUM_W - 1)) state_d = bma_pkg::S_DONE;
      end
      bma_pkg::S_DONE: begin
        if (out_free) state_d = bma_pkg::S_IDLE;
      end
      default: state_d = bma_pkg::S_IDLE;
    endcase
  end

  // Control state: controller state, window size, pointer, full flag, sum, step count and output valid.
  // The reset window size saturates to the ring depth on small rings.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bma_pkg::S_IDLE;
      ws_q        <= (32'(bma_pkg::WindowSizeReset) > WINDOW_MAX) ? DivW'(WINDOW_MAX)
                                                                  : bma_pkg::WindowSizeReset;
      pos_q       <= '0;
      full_q      <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (window_size_we_i) begin
        ws_q   <= ws_clamped;
        pos_q  <= '0;
        full_q <= 1'b0;
        sum_q  <= '0;
      end else if (state_q == bma_pkg::S_READ) begin
        pos_q  <= pos_next;
        full_q <= full_next;
        sum_q  <= sum_next;
      end
      if (state_q == bma_pkg::S_READ) begin
        cnt_q <= '0;
      end else if (state_q == bma_pkg::S_DIV) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (state_q == bma_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (average_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sample ring: read at the pointer on accept, written back in the next cycle.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdata_q  <= ring_q[pos_q];
      sample_q <= sample_i.sample;
    end
    if (state_q == bma_pkg::S_READ) begin
      ring_q[pos_q] <= sample_q;
    end
  end

  // Divider datapath and output payload.
  always_ff @(posedge clk_i) begin
    if (state_q == bma_pkg::S_READ) begin
      div_q <= div_next;
      rem_q <= '0;
      quo_q <= sum_next;
    end else if (state_q == bma_pkg::S_DIV) begin
      rem_q <= fits ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
    if (state_q == bma_pkg::S_DONE && out_free) begin
      out_avg_q <= quo_q[bma_pkg::AverageW-1:0];
    end
  end

  // The write pointer always stays inside the active window.
  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < 32'(ws_q))
    else $error("write pointer outside the window");

  // A window size write clears the running state.
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_size_we_i |=> (sum_q == '0) && !full_q && (pos_q == '0))
    else $error("window size write did not clear the state");

  // A new average only appears after a finished division.
  a_out_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || average_o.ready) && (state_q != bma_pkg::S_DONE) |=> !out_valid_q)
    else $error("average valid without a finished division");

endmodule
